@@ hdl/ftp_pkg.sv @@
package ftp_pkg;

	localparam int unsigned CHAR_W  = 8;
	localparam int unsigned CODE_W  = 5;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned PEND_W  = 7;
	localparam int unsigned CNT_W   = 3;
	localparam int unsigned ACC_W   = PEND_W + CODE_W;

	// output queue sizing
	localparam int unsigned QDEPTH  = 4;
	localparam int unsigned QPTR_W  = $clog2(QDEPTH);
	localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

	// characters with dedicated codes
	localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
	localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;
	localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3B;
	localparam logic [CHAR_W-1:0] CH_PERIOD = 8'h2E;
	localparam logic [CHAR_W-1:0] CH_COLON  = 8'h3A;

	localparam logic [CODE_W-1:0] CODE_SPACE  = 5'd26;
	localparam logic [CODE_W-1:0] CODE_COMMA  = 5'd27;
	localparam logic [CODE_W-1:0] CODE_SEMI   = 5'd28;
	localparam logic [CODE_W-1:0] CODE_PERIOD = 5'd29;
	localparam logic [CODE_W-1:0] CODE_COLON  = 5'd30;
	localparam logic [CHAR_W-1:0] LETTER_BASE = 8'd65;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              last;
	} qentry_t;

	// bytes produced by one character, entry 0 goes out first
	typedef struct packed {
		logic [1:0] n;
		qentry_t    e0;
		qentry_t    e1;
	} push_t;

	function automatic logic [CODE_W-1:0] map_char(input logic [CHAR_W-1:0] c);
		logic [CHAR_W-1:0] diff;
		begin
			diff = c - LETTER_BASE;
			case (c)
				CH_SPACE:  map_char = CODE_SPACE;
				CH_COMMA:  map_char = CODE_COMMA;
				CH_SEMI:   map_char = CODE_SEMI;
				CH_PERIOD: map_char = CODE_PERIOD;
				CH_COLON:  map_char = CODE_COLON;
				default:   map_char = diff[CODE_W-1:0];
			endcase
		end
	endfunction

endpackage

@@ hdl/ftp_pack.sv @@
module ftp_pack (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [ftp_pkg::CHAR_W-1:0]   s_axis_tdata,
	input  logic                         s_axis_tlast,
	input  logic [ftp_pkg::QCNT_W-1:0]   q_count,
	output ftp_pkg::push_t               push
);

	logic                        valid_s1;
	logic [ftp_pkg::CODE_W-1:0]  code_s1;
	logic                        last_s1;
	logic [ftp_pkg::PEND_W-1:0]  bits_q;
	logic [ftp_pkg::CNT_W-1:0]   cnt_q;

	logic [ftp_pkg::ACC_W-1:0]   acc;
	logic                        full;
	logic [ftp_pkg::ACC_W-1:0]   rem;
	logic [ftp_pkg::CNT_W-1:0]   rem_cnt;
	logic                        pad;
	logic [ftp_pkg::QCNT_W:0]    level;

	// shift the new code in above the pending bits
	always_comb begin
		acc = {{ftp_pkg::CODE_W{1'b0}}, bits_q}
			| ({{ftp_pkg::PEND_W{1'b0}}, code_s1} << cnt_q);
		// a byte completes once three or more bits were pending
		full = (cnt_q >= 3'd3);
		if (full) begin
			rem     = acc >> ftp_pkg::BYTE_W;
			rem_cnt = cnt_q - 3'd3;
		end else begin
			rem     = acc;
			rem_cnt = cnt_q + 3'd5;
		end
		pad = last_s1 && (rem_cnt != 3'd0);
	end

	// results of the character in s1
	always_comb begin
		push = '0;
		if (valid_s1) begin
			if (full) begin
				push.n       = pad ? 2'd2 : 2'd1;
				push.e0.data = acc[ftp_pkg::BYTE_W-1:0];
				push.e0.last = last_s1 && !pad;
				push.e1.data = rem[ftp_pkg::BYTE_W-1:0];
				push.e1.last = 1'b1;
			end else if (pad) begin
				push.n       = 2'd1;
				push.e0.data = rem[ftp_pkg::BYTE_W-1:0];
				push.e0.last = 1'b1;
			end
		end
	end

	// room for both the s1 results and a worst case new character
	assign level = {1'b0, q_count} + {{(ftp_pkg::QCNT_W - 1){1'b0}}, push.n};
	assign s_axis_tready = (level <= (ftp_pkg::QCNT_W + 1)'(ftp_pkg::QDEPTH - 2));

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= s_axis_tvalid && s_axis_tready;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			code_s1 <= ftp_pkg::map_char(s_axis_tdata);
			last_s1 <= s_axis_tlast;
		end
	end

	// pending bit accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q <= '0;
			cnt_q  <= '0;
		end else if (valid_s1) begin
			if (last_s1) begin
				bits_q <= '0;
				cnt_q  <= '0;
			end else begin
				bits_q <= rem[ftp_pkg::PEND_W-1:0];
				cnt_q  <= rem_cnt;
			end
		end
	end

	// a last character leaves nothing pending
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && last_s1 |=> cnt_q == 3'd0 && bits_q == '0)
		else $error("pending bits survive a last character");

	// pending bits above the count stay zero
	a_bits_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(bits_q >> cnt_q) == '0)
		else $error("stray pending bits above count");

endmodule

@@ hdl/ftp_queue.sv @@
module ftp_queue (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ftp_pkg::push_t               push,
	output logic [ftp_pkg::QCNT_W-1:0]   q_count,
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [ftp_pkg::BYTE_W-1:0]   m_axis_tdata,
	output logic                         m_axis_tlast
);

	ftp_pkg::qentry_t              mem_q [ftp_pkg::QDEPTH];
	logic [ftp_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [ftp_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [ftp_pkg::QCNT_W-1:0]    count_q;
	logic                          pop;
	logic [ftp_pkg::QPTR_W-1:0]    wr_ptr_nx;

	assign pop           = m_axis_tvalid && m_axis_tready;
	assign wr_ptr_nx     = wr_ptr_q + 1'b1;
	assign q_count       = count_q;
	assign m_axis_tvalid = (count_q != '0);
	assign m_axis_tdata  = mem_q[rd_ptr_q].data;
	assign m_axis_tlast  = mem_q[rd_ptr_q].last;

	// entry storage, up to two writes per cycle
	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wr_ptr_q] <= push.e0;
		end
		if (push.n == 2'd2) begin
			mem_q[wr_ptr_nx] <= push.e1;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + ftp_pkg::QPTR_W'(push.n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + ftp_pkg::QCNT_W'(push.n) - ftp_pkg::QCNT_W'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, count_q} + {{(ftp_pkg::QCNT_W - 1){1'b0}}, push.n})
			<= (ftp_pkg::QCNT_W + 1)'(ftp_pkg::QDEPTH))
		else $error("output queue overflow");

	a_ptr_track: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_ptr_q - rd_ptr_q) == count_q[ftp_pkg::QPTR_W-1:0])
		else $error("queue pointers disagree with count");

endmodule

@@ hdl/five_bit_text_packer_top.sv @@
// channel  | dir | tdata            | tlast
// s_axis   | in  | [7:0] in_char    | is_last
// m_axis   | out | [7:0] out_byte   | last_byte
//
// one character is accepted per cycle while s_axis_tready is high;
// its bytes pass the input register and then the four-entry output queue
// a character yields zero, one or two bytes; a padded final byte follows
// the full one on the next output transfer
// s_axis_tready drops when the queue could not take a worst case character
// arst_n clears the pending bits, the input stage and the queue
module five_bit_text_packer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] in_char
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
	output logic        m_axis_tlast
);

	ftp_pkg::push_t                push;
	logic [ftp_pkg::QCNT_W-1:0]    q_count;

	// character mapping and bit packing
	ftp_pack u_pack (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.q_count       (q_count),
		.push          (push)
	);

	// output byte queue
	ftp_queue u_queue (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.q_count       (q_count),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule
